// File: src/tavg_pkg.sv
// Package for the tile-average glyph quantiser: register codes, glyph codes,
// stage records and queue sizing. No dependencies.
`default_nettype none

package tavg_pkg;

  localparam int SUM_W    = 20;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_TILE_WIDTH   = 3'd1,
    CFG_TILE_HEIGHT  = 3'd2,
    CFG_TILES_ACROSS = 3'd3,
    CFG_TILES_DOWN   = 3'd4
  } cfg_idx_t;

  localparam logic [7:0] GLYPH_HASH    = 8'd35;
  localparam logic [7:0] GLYPH_EQUALS  = 8'd61;
  localparam logic [7:0] GLYPH_STAR    = 8'd42;
  localparam logic [7:0] GLYPH_DOT     = 8'd46;
  localparam logic [7:0] GLYPH_SPACE   = 8'd32;
  localparam logic [7:0] GLYPH_NEWLINE = 8'd10;

  // Clamped configuration as the datapath sees it
  typedef struct packed {
    logic [11:0] fw;
    logic [6:0]  tw;
    logic [6:0]  th;
    logic [7:0]  ta;
    logic [7:0]  td;
  } cfg_t;

  // One pixel as placed by the raster counters
  typedef struct packed {
    logic       active;
    logic       first;
    logic       last;
    logic       nl;
    logic       done;
    logic [7:0] tile_col;
    logic [7:0] gray;
  } pix_req_t;

  // One completed tile
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             nl;
    logic             done;
  } tile_t;

  // One queued item: a glyph, optionally followed by a newline
  typedef struct packed {
    logic [7:0] glyph;
    logic       nl;
    logic       done;
  } entry_t;

endpackage

`default_nettype wire

// File: src/tavg_if.sv
// Handshake interfaces for pixels, results and register writes.
// Stand-alone; no package needed.
`default_nettype none

interface tavg_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       frame_start;
  modport source (output valid, gray, frame_start, input ready);
  modport sink   (input valid, gray, frame_start, output ready);
endinterface

interface tavg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic       last_in_run;
  logic       frame_done;
  modport source (output valid, glyph, last_in_run, frame_done, input ready);
  modport sink   (input valid, glyph, last_in_run, frame_done, output ready);
endinterface

interface tavg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/tavg_raster.sv
// Configuration registers and raster position counters.
// Depends on tavg_pkg and tavg_if.
`default_nettype none

module tavg_raster #(
  parameter int MAX_TILES_ACROSS = 128,
  parameter int MAX_TILE_SIDE    = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  tavg_cfg_if.sink               cfg,
  input  wire logic              accept,
  input  wire logic [7:0]        gray,
  input  wire logic              frame_start,
  output tavg_pkg::pix_req_t     req,
  output tavg_pkg::cfg_t         cfgc
);
  import tavg_pkg::*;

  logic [11:0] frame_width;
  logic [6:0]  tile_width;
  logic [6:0]  tile_height;
  logic [7:0]  tiles_across;
  logic [7:0]  tiles_down;

  logic [11:0] pixel_column, pixel_column_next, pc;
  logic [5:0]  column_in_tile, column_in_tile_next, cit;
  logic [7:0]  tile_column, tile_column_next, tc;
  logic [5:0]  line_in_tile, line_in_tile_next, lit;
  logic [7:0]  tile_row, tile_row_next, tr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      tile_width   <= 7'd8;
      tile_height  <= 7'd16;
      tiles_across <= 8'd80;
      tiles_down   <= 8'd30;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
        CFG_TILE_WIDTH:   tile_width   <= cfg.data[6:0];
        CFG_TILE_HEIGHT:  tile_height  <= cfg.data[6:0];
        CFG_TILES_ACROSS: tiles_across <= cfg.data[7:0];
        CFG_TILES_DOWN:   tiles_down   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversize tile sides and tiles across stop at the maximum
  always_comb begin
    cfgc.fw = (frame_width == 12'd0) ? 12'd1 : frame_width;
    cfgc.tw = (tile_width == 7'd0) ? 7'd1 : tile_width;
    if ({2'b00, tile_width} > 9'(MAX_TILE_SIDE)) cfgc.tw = 7'(MAX_TILE_SIDE);
    cfgc.th = (tile_height == 7'd0) ? 7'd1 : tile_height;
    if ({2'b00, tile_height} > 9'(MAX_TILE_SIDE)) cfgc.th = 7'(MAX_TILE_SIDE);
    cfgc.ta = (tiles_across == 8'd0) ? 8'd1 : tiles_across;
    if ({1'b0, tiles_across} > 9'(MAX_TILES_ACROSS)) cfgc.ta = 8'(MAX_TILES_ACROSS);
    cfgc.td = (tiles_down == 8'd0) ? 8'd1 : tiles_down;
  end

  always_comb begin
    pc  = frame_start ? 12'd0 : pixel_column;
    cit = frame_start ? 6'd0  : column_in_tile;
    tc  = frame_start ? 8'd0  : tile_column;
    lit = frame_start ? 6'd0  : line_in_tile;
    tr  = frame_start ? 8'd0  : tile_row;

    req.active   = (tc < cfgc.ta) && (tr < cfgc.td);
    req.first    = (cit == 6'd0) && (lit == 6'd0);
    req.last     = ({1'b0, cit} == cfgc.tw - 7'd1) && ({1'b0, lit} == cfgc.th - 7'd1);
    req.nl       = (tc == cfgc.ta - 8'd1);
    req.done     = (tr == cfgc.td - 8'd1);
    req.tile_col = tc;
    req.gray     = gray;

    column_in_tile_next = cit + 6'd1;
    tile_column_next    = tc;
    if ({1'b0, column_in_tile_next} >= cfgc.tw || column_in_tile_next == 6'd0) begin
      column_in_tile_next = 6'd0;
      if (tc < cfgc.ta) tile_column_next = tc + 8'd1;
    end
    pixel_column_next = pc + 12'd1;
    line_in_tile_next = lit;
    tile_row_next     = tr;
    if (pixel_column_next >= cfgc.fw || pixel_column_next == 12'd0) begin
      pixel_column_next   = 12'd0;
      column_in_tile_next = 6'd0;
      tile_column_next    = 8'd0;
      line_in_tile_next   = lit + 6'd1;
      if ({1'b0, line_in_tile_next} >= cfgc.th || line_in_tile_next == 6'd0) begin
        line_in_tile_next = 6'd0;
        if (tr < cfgc.td) tile_row_next = tr + 8'd1;
      end
    end
    if (tile_column_next > cfgc.ta) tile_column_next = cfgc.ta;
    if (tile_row_next > cfgc.td) tile_row_next = cfgc.td;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column   <= 12'd0;
      column_in_tile <= 6'd0;
      tile_column    <= 8'd0;
      line_in_tile   <= 6'd0;
      tile_row       <= 8'd0;
    end else if (accept) begin
      pixel_column   <= pixel_column_next;
      column_in_tile <= column_in_tile_next;
      tile_column    <= tile_column_next;
      line_in_tile   <= line_in_tile_next;
      tile_row       <= tile_row_next;
    end
  end

endmodule

`default_nettype wire

// File: src/tavg_accum.sv
// Column accumulator memory with read-modify-write and same-entry forwarding.
// Depends on tavg_pkg.
`default_nettype none

module tavg_accum #(
  parameter int MAX_TILES_ACROSS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire tavg_pkg::pix_req_t req,
  output logic                    s1_pending,
  output tavg_pkg::tile_t         tile
);
  import tavg_pkg::*;

  localparam int IDX_W = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;

  logic [SUM_W-1:0] mem [MAX_TILES_ACROSS];
  logic [SUM_W-1:0] rdata;

  logic             s1_valid;
  pix_req_t         s1;
  logic             s1_fwd;
  logic [SUM_W-1:0] s1_fwd_data;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic             s1_we;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] s1_idx;

  assign rd_idx = req.tile_col[IDX_W-1:0];
  assign s1_idx = s1.tile_col[IDX_W-1:0];
  assign s1_we  = s1_valid && s1.active;

  always_ff @(posedge clk) begin
    if (accept) rdata <= mem[rd_idx];
    if (s1_we) mem[s1_idx] <= sum;
  end

  // A write in flight to the entry being read lands too late for the read port
  always_comb begin
    base = s1_fwd ? s1_fwd_data : rdata;
    sum  = s1.first ? {{(SUM_W-8){1'b0}}, s1.gray} : base + {{(SUM_W-8){1'b0}}, s1.gray};
  end

  assign s1_pending = s1_we && s1.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      tile.valid <= 1'b0;
    end else begin
      s1_valid   <= accept;
      tile.valid <= s1_pending;
    end
    if (accept) begin
      s1          <= req;
      s1_fwd      <= s1_we && (s1_idx == rd_idx);
      s1_fwd_data <= sum;
    end
    tile.sum  <= sum;
    tile.nl   <= s1.nl;
    tile.done <= s1.done;
  end

endmodule

`default_nettype wire

// File: src/tavg_quant.sv
// Threshold registers and glyph selection from a tile sum.
// Depends on tavg_pkg.
`default_nettype none

module tavg_quant (
  input  wire logic            clk,
  input  wire tavg_pkg::cfg_t  cfgc,
  input  wire tavg_pkg::tile_t tile,
  output logic                 push,
  output tavg_pkg::entry_t     entry
);
  import tavg_pkg::*;

  logic [13:0]         n;
  logic [23:0]         thr_hash;
  logic [22:0]         thr_equals;
  logic [21:0]         thr_star;
  logic [18:0]         thr_dot;
  logic [SUM_W+1:0]    sum4;

  // Thresholds follow the tile size through the registered product n, then the threshold registers
  always_ff @(posedge clk) begin
    n          <= {7'd0, cfgc.tw} * {7'd0, cfgc.th};
    thr_hash   <= {10'd0, n} * 24'd765;
    thr_equals <= {9'd0, n} * 23'd510;
    thr_star   <= {8'd0, n} * 22'd255;
    thr_dot    <= {5'd0, n} * 19'd20;
  end

  assign sum4 = {tile.sum, 2'b00};

  always_comb begin
    if ({2'b00, sum4} >= thr_hash)            entry.glyph = GLYPH_HASH;
    else if ({1'b0, sum4} >= thr_equals)      entry.glyph = GLYPH_EQUALS;
    else if (sum4 >= thr_star)                entry.glyph = GLYPH_STAR;
    else if (tile.sum >= {1'b0, thr_dot})     entry.glyph = GLYPH_DOT;
    else                                      entry.glyph = GLYPH_SPACE;
    entry.nl   = tile.nl;
    entry.done = tile.done;
    push       = tile.valid;
  end

endmodule

`default_nettype wire

// File: src/tavg_outq.sv
// Result queue: one entry per tile, unpacked into a glyph and an optional newline.
// Depends on tavg_pkg and tavg_if.
`default_nettype none

module tavg_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tavg_pkg::entry_t entry,
  input  wire logic [1:0]       in_flight,
  output logic                  room,
  tavg_result_if.source         result
);
  import tavg_pkg::*;

  entry_t             q [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_ptr;
  logic [OQ_AW-1:0]   rd_ptr;
  logic [OQ_AW:0]     count;
  logic               phase;
  logic               take;
  logic               pop;
  entry_t             head;

  assign head = q[rd_ptr];
  assign take = result.valid && result.ready;
  assign pop  = take && (phase || !head.nl);

  // Leave space for every tile still in the pipeline plus the new pixel
  assign room = ({1'b0, count} + {{OQ_AW{1'b0}}, in_flight}) < (OQ_AW+2)'(OQ_DEPTH);

  assign result.valid       = (count != '0);
  assign result.glyph       = phase ? GLYPH_NEWLINE : head.glyph;
  assign result.last_in_run = phase || !head.nl;
  assign result.frame_done  = phase && head.done;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      if (take) phase <= !pop;
    end
  end

endmodule

`default_nettype wire

// File: src/tile_average_to_ascii_glyph.sv
// Tile-average glyph quantiser, top level.
// Throughput: one pixel per cycle while the queue has room. A tile glyph is offered after
// the s1, tile and queue registers; its newline in the cycle after the glyph is taken.
// Input stalls only when the eight-entry result queue cannot hold every tile in flight.
// Reset (rst, synchronous) loads the register defaults, clears counters and queue;
// accumulator memory is not cleared, each tile's top-left pixel overwrites its entry.
`default_nettype none

module tile_average_to_ascii_glyph #(
  parameter int MAX_TILES_ACROSS = 128,
  parameter int MAX_TILE_SIDE    = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  tavg_pixel_if.sink     pixel,
  tavg_result_if.source  result,
  tavg_cfg_if.sink       cfg
);
  import tavg_pkg::*;

  pix_req_t req;
  cfg_t     cfgc;
  tile_t    tile;
  entry_t   entry;
  logic     accept;
  logic     room;
  logic     push;
  logic     s1_pending;
  logic [1:0] in_flight;

  assign pixel.ready = room;
  assign accept      = pixel.valid && room;
  assign in_flight   = {1'b0, s1_pending} + {1'b0, tile.valid};

  tavg_raster #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILE_SIDE    (MAX_TILE_SIDE)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .gray        (pixel.gray),
    .frame_start (pixel.frame_start),
    .req         (req),
    .cfgc        (cfgc)
  );

  tavg_accum #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (req),
    .s1_pending (s1_pending),
    .tile       (tile)
  );

  tavg_quant u_quant (
    .clk   (clk),
    .cfgc  (cfgc),
    .tile  (tile),
    .push  (push),
    .entry (entry)
  );

  tavg_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .in_flight (in_flight),
    .room      (room),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: src/tavg_checker.sv
// Port-level checks on the result stream of the glyph quantiser.
// Bound to tile_average_to_ascii_glyph; takes glyph codes from tavg_pkg.
`default_nettype none

module tavg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] glyph,
  input wire logic       last_in_run,
  input wire logic       frame_done
);
  import tavg_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result offered straight after reset");

  a_done_on_newline: assert property (@(posedge clk) disable iff (rst)
    valid && frame_done |-> last_in_run && glyph == GLYPH_NEWLINE)
    else $error("frame_done away from a final newline");

  a_glyph_set: assert property (@(posedge clk) disable iff (rst)
    valid |-> glyph == GLYPH_SPACE || glyph == GLYPH_DOT || glyph == GLYPH_STAR ||
              glyph == GLYPH_EQUALS || glyph == GLYPH_HASH || glyph == GLYPH_NEWLINE)
    else $error("glyph outside the code set");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(glyph) && $stable(last_in_run) &&
                        $stable(frame_done))
    else $error("stalled result changed");

endmodule

bind tile_average_to_ascii_glyph tavg_checker u_tavg_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .glyph       (result.glyph),
  .last_in_run (result.last_in_run),
  .frame_done  (result.frame_done)
);

`default_nettype wire
